// ===== rtl/flptm_pkg.sv =====
// Package with shared types, constants and helpers for the page table mapper.
`timescale 1ns / 1ps

package flptm_pkg;

  localparam int NUM_FRAMES = 32;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int IDX_W = $clog2(ENTRIES_PER_FRAME);
  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int ADDR_W = FRAME_W + IDX_W;
  localparam int DEPTH = NUM_FRAMES * ENTRIES_PER_FRAME;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int PFN_W = 40;
  localparam int SELF_SLOT = 510;

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] virtual_address;
    logic [51:0] physical_address;
    logic [63:0] map_flags;
    logic [4:0]  read_frame;
    logic [8:0]  read_index;
  } flptm_req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] read_data;
    logic [5:0]  frames_in_use;
  } flptm_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       data;
  } flptm_wr_t;

  // Table pointer to a pool frame: frame number plus base, with write and present set.
  function automatic logic [63:0] pointer_to(input logic [PFN_W-1:0] base,
                                             input logic [FRAME_W-1:0] frame);
    logic [PFN_W-1:0] pfn;
    pfn = base + PFN_W'(frame);
    return {12'd0, pfn, 10'd0, 2'b11};
  endfunction

endpackage

// ===== rtl/flptm_ram.sv =====
// Generic single write port, single read port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module flptm_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 64,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/flptm_ctrl.sv =====
// Sequencer for the clearing pass, the table walk, the table writes and the result.
`timescale 1ns / 1ps

module flptm_ctrl import flptm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  flptm_req_t        req_i,
  input  logic [PFN_W-1:0]  pool_base_i,
  input  logic              cfg_we_i,
  input  logic [63:0]       rdata_i,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  output flptm_wr_t         wr_o,
  output logic              done_o,
  output flptm_rsp_t        rsp_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  logic [2:0]         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [1:0]         lvl_q, lvl_d;
  logic [FRAME_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]   nf_q, nf_d;
  logic               rd_ok_q, rd_ok_d;
  logic               done_q, done_d;
  flptm_req_t         req_q, req_d;
  flptm_rsp_t         rsp_q, rsp_d;

  logic [PFN_W-1:0]   rel;
  logic               rel_ok;
  logic [1:0]         need;
  logic               short;

  function automatic logic [IDX_W-1:0] idx_of(input logic [63:0] va, input logic [1:0] l);
    logic [IDX_W-1:0] r;
    case (l)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

  // Frame that a stored pointer names, relative to the pool, and whether it is allocated.
  assign rel    = rdata_i[51:12] - pool_base_i;
  assign rel_ok = rel < PFN_W'(nf_q);
  assign need   = LVL_LEAF - lvl_q;
  assign short  = ((CNT_W + 1)'(nf_q) + (CNT_W + 1)'(need)) > (CNT_W + 1)'(NUM_FRAMES);

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    lvl_d     = lvl_q;
    cur_d     = cur_q;
    nf_d      = nf_q;
    rd_ok_d   = rd_ok_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_o      = '0;

    case (state_q)
      S_CLEAR: begin
        // A configuration write owns the write port; the sweep waits for it.
        if (!cfg_we_i) begin
          wr_o.en   = 1'b1;
          wr_o.addr = clr_q;
          wr_o.data = (clr_q == ADDR_W'(SELF_SLOT)) ? pointer_to(pool_base_i, '0) : '0;
          clr_d     = clr_q + 1'b1;
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          lvl_d   = 2'd0;
          cur_d   = '0;
          rd_ok_d = 32'(req_i.read_frame) < 32'(NUM_FRAMES);
          rd_en_o = 1'b1;
          if (req_i.operation == OP_READ) begin
            rd_addr_o = {FRAME_W'(req_i.read_frame), req_i.read_index};
            state_d   = S_READ;
          end else begin
            rd_addr_o = {{FRAME_W{1'b0}}, idx_of(req_i.virtual_address, 2'd0)};
            state_d   = S_WALK;
          end
        end
      end

      S_READ: begin
        rsp_d.status        = ST_DONE;
        rsp_d.read_data     = rd_ok_q ? rdata_i : '0;
        rsp_d.frames_in_use = 6'(nf_q);
        done_d              = 1'b1;
        state_d             = S_IDLE;
      end

      S_WALK: begin
        rsp_d.status        = ST_REFUSED;
        rsp_d.read_data     = '0;
        rsp_d.frames_in_use = 6'(nf_q);
        if (!rdata_i[0]) begin
          // Missing table: allocate the rest of the path if the pool has room.
          if (short) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_WRITE;
          end
        end else if (!rel_ok) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d = rel[FRAME_W-1:0];
          if (lvl_q == 2'd2) begin
            lvl_d   = LVL_LEAF;
            state_d = S_WRITE;
          end else begin
            lvl_d     = lvl_q + 1'b1;
            rd_en_o   = 1'b1;
            rd_addr_o = {rel[FRAME_W-1:0], idx_of(req_q.virtual_address, lvl_q + 1'b1)};
          end
        end
      end

      S_WRITE: begin
        wr_o.en   = 1'b1;
        wr_o.addr = {cur_q, idx_of(req_q.virtual_address, lvl_q)};
        if (lvl_q == LVL_LEAF) begin
          wr_o.data           = {12'd0, req_q.physical_address} | req_q.map_flags;
          rsp_d.status        = ST_DONE;
          rsp_d.read_data     = '0;
          rsp_d.frames_in_use = 6'(nf_q);
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else begin
          // Fresh frames are still zero, so every lower level is missing too.
          wr_o.data = pointer_to(pool_base_i, nf_q[FRAME_W-1:0]);
          cur_d     = nf_q[FRAME_W-1:0];
          nf_d      = nf_q + 1'b1;
          lvl_d     = lvl_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      lvl_q   <= '0;
      cur_q   <= '0;
      nf_q    <= CNT_W'(1);
      rd_ok_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lvl_q   <= lvl_d;
      cur_q   <= cur_d;
      nf_q    <= nf_d;
      rd_ok_q <= rd_ok_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_write_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (CNT_W'(cur_q) < nf_q))
    else $error("table write targets a frame that is not allocated");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= CNT_W'(NUM_FRAMES))
    else $error("frame count beyond pool size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_READ || $past(state_q) == S_WALK ||
                $past(state_q) == S_WRITE))
    else $error("result strobe without a finishing transaction");

  a_refuse_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == ST_REFUSED) |-> $stable(nf_q))
    else $error("refused map changed the frame count");
`endif

endmodule

// ===== rtl/four_level_page_table_mapper.sv =====
// Top level of the four-level page table mapper: configuration, table RAM and sequencer.
`timescale 1ns / 1ps
//
// Channel        Signals                      Direction  Transaction completes when
// request        start, busy, req_i           in         start high and busy low at clk edge
// result         done_o, rsp_o                out        done_o high (one cycle, no stall)
// configuration  cfg_we_i, cfg_wdata_i        in         cfg_we_i high at clk edge
//
// A read transaction reads the table RAM in the accept cycle; the word leaves the RAM's
// read register and the result strobe is registered from it in the cycle after.
// A map transaction walks up to three table levels, one table RAM read each, then
// writes one entry per missing table and one for the leaf entry; busy drops in the
// same cycle as the result strobe shows, also when the walk ends in a refusal.
// A new request is taken while that strobe shows.
// After reset the sequencer sweeps all 16384 table words, pausing for each configuration
// write during the sweep, holding busy high; the root entry 510 is written as the
// self-reference while every other word is cleared.
// The receiver cannot stall results, so none are ever held back.

module four_level_page_table_mapper import flptm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  flptm_req_t       req_i,
  input  logic             cfg_we_i,
  input  logic [PFN_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output flptm_rsp_t       rsp_o
);

  logic [PFN_W-1:0]  pool_base_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [63:0]       rdata;
  flptm_wr_t         seq_wr;
  flptm_wr_t         ram_wr;

  // The pool base register. Writing it also rewrites the root self-reference, which
  // is done through the shared write port below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_we_i) begin
      pool_base_q <= cfg_wdata_i;
    end
  end

  // A configuration write must only arrive while the sequencer is idle or sweeping (the
  // block does not enforce this); the sweep pauses for it and the configuration side takes priority.
  always_comb begin
    if (cfg_we_i) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = ADDR_W'(SELF_SLOT);
      ram_wr.data = pointer_to(cfg_wdata_i, '0);
    end else begin
      ram_wr = seq_wr;
    end
  end

  flptm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (64)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  flptm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .pool_base_i (pool_base_q),
    .cfg_we_i    (cfg_we_i),
    .rdata_i     (rdata),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_o        (seq_wr),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== tb/page_map_checker.sv =====
// Checker for the page table mapper: mirrors the table pool and compares every result.
`timescale 1ns / 1ps

module page_map_checker import flptm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  flptm_req_t       req_i,
  input  logic             cfg_we_i,
  input  logic [PFN_W-1:0] cfg_wdata_i,
  input  logic             done_o,
  input  flptm_rsp_t       rsp_o,
  output int               fail_count_o,
  output int               pending_o
);

  logic [63:0]      shadow_tables [DEPTH];
  int unsigned      frames_taken;
  logic [PFN_W-1:0] pool_base;
  flptm_rsp_t       awaited_rsp_q [$];

  // Table pointer word for a pool frame under the current base.
  function automatic logic [63:0] link_word(input int unsigned frame);
    logic [PFN_W-1:0] pfn;
    pfn = pool_base + PFN_W'(frame);
    return (64'(pfn) << 12) | 64'h3;
  endfunction

  // A pointer is usable only when it lands on a frame already handed out.
  function automatic logic resolve_link(input logic [63:0] entry, output int unsigned frame);
    logic [PFN_W-1:0] rel;
    rel = entry[51:12] - pool_base;
    frame = 0;
    if (rel >= PFN_W'(frames_taken) || rel >= PFN_W'(NUM_FRAMES)) return 1'b0;
    frame = 32'(rel);
    return 1'b1;
  endfunction

  function automatic int unsigned slot(input int unsigned frame, input logic [8:0] index);
    return frame * ENTRIES_PER_FRAME + index;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < DEPTH; i++) shadow_tables[i] = '0;
    pool_base = '0;
    frames_taken = 1;
    shadow_tables[SELF_SLOT] = link_word(0);
  endtask

  // Applies one transaction to the shadow pool and returns the result it must produce.
  function automatic flptm_rsp_t apply_request(input flptm_req_t r);
    flptm_rsp_t  res;
    logic [8:0]  lvl_idx [4];
    logic [63:0] entry;
    int unsigned cur;
    int unsigned nxt;
    int unsigned need;
    logic        refused;
    res = '0;
    cur = 0;
    need = 0;
    refused = 1'b0;
    if (r.operation == OP_READ) begin
      if (r.read_frame < NUM_FRAMES) res.read_data = shadow_tables[slot(r.read_frame, r.read_index)];
    end else begin
      lvl_idx[0] = r.virtual_address[47:39];
      lvl_idx[1] = r.virtual_address[38:30];
      lvl_idx[2] = r.virtual_address[29:21];
      lvl_idx[3] = r.virtual_address[20:12];
      // First pass only counts the tables that are missing and spots bad pointers.
      for (int lvl = 0; lvl < 3; lvl++) begin
        entry = shadow_tables[slot(cur, lvl_idx[lvl])];
        if (!entry[0]) begin
          need = 3 - lvl;
          break;
        end
        if (!resolve_link(entry, nxt)) begin
          refused = 1'b1;
          break;
        end
        cur = nxt;
      end
      if (refused || frames_taken + need > NUM_FRAMES) begin
        res.status = ST_REFUSED;
      end else begin
        cur = 0;
        for (int lvl = 0; lvl < 3; lvl++) begin
          entry = shadow_tables[slot(cur, lvl_idx[lvl])];
          if (entry[0] && resolve_link(entry, nxt)) begin
            cur = nxt;
          end else begin
            nxt = frames_taken;
            if (nxt >= NUM_FRAMES) nxt = NUM_FRAMES - 1;
            else frames_taken++;
            shadow_tables[slot(cur, lvl_idx[lvl])] = link_word(nxt);
            cur = nxt;
          end
        end
        shadow_tables[slot(cur, lvl_idx[3])] = {12'd0, r.physical_address} | r.map_flags;
      end
    end
    res.frames_in_use = 6'(frames_taken);
    return res;
  endfunction

  always @(posedge clk_i) begin
    flptm_rsp_t want;
    if (!rst_ni) begin
      clear_tables();
      awaited_rsp_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        pool_base = cfg_wdata_i;
        shadow_tables[SELF_SLOT] = link_word(0);
      end
      // A result that shows together with a new request belongs to the older one.
      if (done_o) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          fail_count_o++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0h, actual %0h", want.status, rsp_o.status);
            fail_count_o++;
          end
          if (rsp_o.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, rsp_o.read_data);
            fail_count_o++;
          end
          if (rsp_o.frames_in_use !== want.frames_in_use) begin
            $error("frames_in_use: expected %0d, actual %0d", want.frames_in_use,
                   rsp_o.frames_in_use);
            fail_count_o++;
          end
        end
      end
      if (start && !busy) awaited_rsp_q.push_back(apply_request(req_i));
    end
    pending_o = awaited_rsp_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the page table mapper: stimulus, clock, reset and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import flptm_pkg::*;

  // The bound covers the post-reset sweep and every transaction with its longest
  // sender gap, and is several times the slowest correct run.
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 130;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  flptm_req_t       req_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [PFN_W-1:0] cfg_wdata_i = '0;
  logic             done_o;
  flptm_rsp_t       rsp_o;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;

  four_level_page_table_mapper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  page_map_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a result that never arrives ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Every field random, so that the fields a transaction ignores still toggle.
  function automatic flptm_req_t random_fill();
    flptm_req_t r;
    r.operation        = 1'($urandom);
    r.virtual_address  = {$urandom, $urandom};
    r.physical_address = 52'({$urandom, $urandom});
    r.map_flags        = {$urandom, $urandom};
    r.read_frame       = 5'($urandom);
    r.read_index       = 9'($urandom);
    return r;
  endfunction

  // Virtual address with the four table indices placed in bits 47..12 and random
  // bits around them, which the block must ignore.
  function automatic logic [63:0] va_at(input logic [8:0] i0, input logic [8:0] i1,
                                        input logic [8:0] i2, input logic [8:0] i3);
    logic [63:0] va;
    va = {$urandom, $urandom};
    va[47:12] = {i0, i1, i2, i3};
    return va;
  endfunction

  function automatic flptm_req_t build_map(input logic [63:0] va, input logic [51:0] phys,
                                           input logic [63:0] flags);
    flptm_req_t r;
    r = random_fill();
    r.operation        = OP_MAP;
    r.virtual_address  = va;
    r.physical_address = phys;
    r.map_flags        = flags;
    return r;
  endfunction

  function automatic flptm_req_t build_read(input logic [4:0] frame, input logic [8:0] index);
    flptm_req_t r;
    r = random_fill();
    r.operation  = OP_READ;
    r.read_frame = frame;
    r.read_index = index;
    return r;
  endfunction

  // Offers one transaction after a random idle gap and returns once it is accepted.
  // Start stays high afterwards so that back-to-back transactions need no bubble.
  task automatic send(input flptm_req_t r, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stops offering work and waits until every outstanding transaction has reported.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_pool_base(input logic [PFN_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    flptm_req_t       directed_q [$];
    flptm_req_t       item;
    logic [8:0]       i0, i1, i2, i3;
    logic [PFN_W-1:0] phase_base;
    int               idle_pct;
    int unsigned      pick;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing sweep finish before the first configuration write.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    write_pool_base('0);

    // Directed part. The self-reference and an untouched word come first.
    directed_q.push_back(build_read(5'd0, 9'(SELF_SLOT)));
    directed_q.push_back(build_read(5'd0, 9'd0));
    // Field extremes: the all-zero address with the widest physical page, then the
    // all-ones address with every flag set. Each of these builds a fresh path.
    directed_q.push_back(build_map(64'd0, '1, 64'd0));
    directed_q.push_back(build_map('1, 52'd0, '1));
    // Second page on an existing path: no new tables are needed.
    directed_q.push_back(build_map(va_at(9'd0, 9'd0, 9'd0, 9'd1), 52'({$urandom, $urandom}),
                                   {$urandom, $urandom}));
    directed_q.push_back(build_read(5'd1, 9'd0));
    directed_q.push_back(build_read(5'd2, 9'd0));
    directed_q.push_back(build_read(5'd3, 9'd1));
    // Walking through the recursive slot three times makes the root its own leaf
    // table, so this plants a present pointer far outside the pool in root entry 5.
    directed_q.push_back(build_map(va_at(9'(SELF_SLOT), 9'(SELF_SLOT), 9'(SELF_SLOT), 9'd5),
                                   52'hA_BCDE_F012_3000, 64'h3));
    directed_q.push_back(build_map(va_at(9'd5, 9'd0, 9'd0, 9'd0), '1, 64'h1));
    directed_q.push_back(build_read(5'd0, 9'd5));
    // Fresh paths at roots 10 to 18 use three frames each; the last one no longer
    // fits and must leave the pool untouched.
    for (int r = 10; r <= 18; r++) begin
      directed_q.push_back(build_map(va_at(9'(r), 9'(r), 9'(r), 9'd0),
                                     52'({$urandom, $urandom}), {$urandom, $urandom}));
    end
    // One frame is left: a new last-level table takes it, the next one is refused.
    directed_q.push_back(build_map(va_at(9'd10, 9'd10, 9'd11, 9'd0), 52'h1, 64'h0));
    directed_q.push_back(build_map(va_at(9'd11, 9'd11, 9'd12, 9'd0), 52'h2, 64'h0));
    directed_q.push_back(build_read(5'd31, 9'd0));
    foreach (directed_q[k]) send(directed_q[k], 0);
    settle();

    // Random part. Each phase sets a pool base and an idle rate. Returning to an
    // earlier base makes the stored pointers valid again; an all-ones base wraps the
    // frame numbers so old pointers resolve to neighboring frames.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 2, 5: phase_base = '0;
        1, 6:    phase_base = '1;
        4:       phase_base = PFN_W'(1);
        default: phase_base = PFN_W'({$urandom, $urandom});
      endcase
      case (phase % 4)
        1:       idle_pct = 70;
        3:       idle_pct = 30;
        default: idle_pct = 0;
      endcase
      write_pool_base(phase_base);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          // Mostly maps that reuse the paths built above, so leaves get rewritten
          // and read back; the rest are recursive writes into the root and random
          // paths, which mostly hit the exhausted pool.
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            i0 = 9'(SELF_SLOT);
            i1 = 9'(SELF_SLOT);
            i2 = 9'(SELF_SLOT);
          end else if (pick < 18) begin
            i0 = 9'($urandom);
            i1 = 9'($urandom);
            i2 = 9'($urandom);
          end else begin
            case ($urandom_range(0, 3))
              0:       i0 = 9'd0;
              1:       i0 = 9'd511;
              default: i0 = 9'(10 + $urandom_range(0, 7));
            endcase
            i1 = i0;
            i2 = i0;
            if ($urandom_range(0, 9) == 0) i2 = 9'($urandom);
          end
          if (pick < 8 || $urandom_range(0, 1) == 0) i3 = 9'($urandom);
          else i3 = 9'($urandom_range(0, 7));
          item = build_map(va_at(i0, i1, i2, i3), 52'({$urandom, $urandom}),
                           ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom});
        end else begin
          // Reads favor the low leaf slots and the root slots that hold pointers.
          pick = $urandom_range(0, 9);
          if (pick < 5) i3 = 9'($urandom_range(0, 7));
          else if (pick < 7) i3 = 9'(10 + $urandom_range(0, 7));
          else if (pick < 8) i3 = 9'(SELF_SLOT);
          else i3 = 9'($urandom);
          item = build_read(5'($urandom), i3);
        end
        send(item, idle_pct);
      end
      // The sender holds off here until every result is in, which also makes the
      // next configuration write safe.
      settle();
    end

    // Room for a stray result strobe to show up after the last expected one.
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
